// ===== rtl/tcce_pkg.sv =====
// Shared types, constants and codes for the text console cursor engine.
package tcce_pkg;

    localparam int COORD_BITS = 12;
    localparam int POS_BITS   = 12;
    localparam int CMP_W      = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 2;
    localparam int TAB_SHIFT  = 5;

    localparam logic [CMP_W-1:0] HOME_X   = CMP_W'(10);
    localparam logic [CMP_W-1:0] HOME_Y   = CMP_W'(10);
    localparam logic [CMP_W-1:0] BS_LIMIT = CMP_W'(26);
    localparam logic [CMP_W-1:0] CELL_W   = CMP_W'(8);
    localparam logic [CMP_W-1:0] TAB_STEP = CMP_W'(1) << TAB_SHIFT;

    localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(10);
    localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(50);

    localparam logic [11:0] RESET_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RESET_SCREEN_HEIGHT = 12'd480;
    localparam logic [5:0]  RESET_CHAR_HEIGHT   = 6'd16;
    localparam logic [23:0] RESET_FG_COLOR      = 24'hFFFFFF;
    localparam logic [23:0] ERASE_COLOR         = 24'h000000;
    localparam logic [7:0]  ERASE_GLYPH         = 8'h00;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;

    typedef enum logic {
        CMD_PUT_CHAR   = 1'b0,
        CMD_SET_CURSOR = 1'b1
    } cmd_t;

    typedef enum logic {
        DRAW_GLYPH = 1'b0,
        DRAW_ERASE = 1'b1
    } draw_kind_t;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_CHAR_HEIGHT   = 2'd2,
        REG_FG_COLOR      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [5:0]  char_height;
        logic [23:0] fg_color;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  char_code;
        logic [11:0] new_x;
        logic [11:0] new_y;
    } item_t;

    typedef struct packed {
        draw_kind_t  draw_kind;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  glyph_code;
        logic [23:0] pixel_color;
    } result_t;

endpackage

// ===== rtl/tcce_cfg.sv =====
// APB register file holding the console geometry and text color.
module tcce_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output tcce_pkg::cfg_t       cfg
);
    import tcce_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[11:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[11:0];
                REG_CHAR_HEIGHT:   cfg_next.char_height   = pwdata[5:0];
                REG_FG_COLOR:      cfg_next.fg_color      = pwdata[23:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCREEN_WIDTH:  prdata = {20'd0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {20'd0, cfg_reg.screen_height};
            REG_CHAR_HEIGHT:   prdata = {26'd0, cfg_reg.char_height};
            REG_FG_COLOR:      prdata = {8'd0, cfg_reg.fg_color};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= RESET_SCREEN_WIDTH;
            cfg_reg.screen_height <= RESET_SCREEN_HEIGHT;
            cfg_reg.char_height   <= RESET_CHAR_HEIGHT;
            cfg_reg.fg_color      <= RESET_FG_COLOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/tcce_step.sv =====
// Cursor registers and the per-character update and draw command logic.
module tcce_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcce_pkg::cfg_t    cfg,
    input  tcce_pkg::item_t   item,
    input  logic              advance,
    output tcce_pkg::result_t res,
    output logic              res_valid
);
    import tcce_pkg::*;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;

    logic [CMP_W-1:0] x_ext, y_ext, ch_ext;
    logic [CMP_W-1:0] x_edge, y_edge;
    logic [CMP_W-1:0] line_y, wrap_y, glyph_x, tab_x, bs_x;

    always_comb begin
        x_ext  = CMP_W'(cur_x_reg);
        y_ext  = CMP_W'(cur_y_reg);
        ch_ext = CMP_W'(cfg.char_height);

        // Edges saturate at zero on tiny screens, forcing the wrap.
        x_edge = (CMP_W'(cfg.screen_width) > CELL_W) ?
                 CMP_W'(cfg.screen_width) - CELL_W : '0;
        y_edge = (CMP_W'(cfg.screen_height) > ch_ext) ?
                 CMP_W'(cfg.screen_height) - ch_ext : '0;

        line_y  = y_ext + ch_ext;
        wrap_y  = (line_y >= y_edge) ? HOME_Y : line_y;
        glyph_x = x_ext + CELL_W;
        tab_x   = ((x_ext >> TAB_SHIFT) << TAB_SHIFT) + TAB_STEP;
        bs_x    = x_ext - CELL_W;
    end

    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        res_valid       = 1'b0;
        res.draw_kind   = DRAW_GLYPH;
        res.pos_x       = POS_BITS'(cur_x_reg);
        res.pos_y       = POS_BITS'(cur_y_reg);
        res.glyph_code  = item.char_code;
        res.pixel_color = cfg.fg_color;

        if (item.cmd == CMD_SET_CURSOR) begin
            cur_x_next = COORD_BITS'(item.new_x);
            cur_y_next = COORD_BITS'(item.new_y);
        end else begin
            case (item.char_code)
                CH_BACKSPACE: begin
                    if (x_ext > BS_LIMIT) begin
                        cur_x_next      = COORD_BITS'(bs_x);
                        res_valid       = 1'b1;
                        res.draw_kind   = DRAW_ERASE;
                        res.pos_x       = POS_BITS'(bs_x);
                        res.glyph_code  = ERASE_GLYPH;
                        res.pixel_color = ERASE_COLOR;
                    end
                end
                CH_NEWLINE: begin
                    cur_x_next = COORD_BITS'(HOME_X);
                    cur_y_next = COORD_BITS'(wrap_y);
                end
                CH_TAB: begin
                    // Past the right edge: new line without the bottom wrap.
                    if (tab_x >= x_edge) begin
                        cur_x_next = COORD_BITS'(HOME_X);
                        cur_y_next = COORD_BITS'(line_y);
                    end else begin
                        cur_x_next = COORD_BITS'(tab_x);
                    end
                end
                default: begin
                    res_valid = 1'b1;
                    if (glyph_x >= x_edge) begin
                        cur_x_next = COORD_BITS'(HOME_X);
                        cur_y_next = COORD_BITS'(wrap_y);
                    end else begin
                        cur_x_next = COORD_BITS'(glyph_x);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= RESET_X;
            cur_y_reg <= RESET_Y;
        end else if (advance) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

endmodule

// ===== rtl/text_console_cursor_engine_top.sv =====
// Top level of the text console cursor engine: stream ports, APB port, pipeline registers.
//
// Usage:
//   s_ channel carries one character or set-cursor command per transaction.
//   s_tuser[0] is the command (0 put character, 1 set cursor). s_tdata holds
//   the character code and the new cursor coordinates.
//   m_ channel carries draw commands: an erase cell for a backspace that
//   moves the cursor and a glyph cell for any other character code. Newline,
//   tab, a blocked backspace and set cursor produce no transaction.
//   The accepting edge loads the input register; the result register, which
//   drives m_, loads when the item advances.
//   Throughput: one transaction per cycle while m_ does not stall; the cursor
//   update is a short combinational compare-and-add between the two registers.
//   Stall: when m_tready is low and the result register is full, an item that
//   draws waits in the input register and s_tready falls; items that draw
//   nothing still pass. No transaction is lost or repeated.
//   Reset: aresetn (synchronous, active low) empties both registers, puts the
//   cursor at (10, 50) and loads 640x480, char height 16, white text.
//   APB registers: 0x0 width, 0x4 height, 0x8 char height, 0xC text color;
//   write them only while the block is idle.
module text_console_cursor_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] char_code, [19:8] new_x, [31:20] new_y
    input  logic [0:0]  s_tuser,   // [0] cmd
    // Draw command stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [11:0] pos_x, [23:12] pos_y, [31:24] glyph_code,
                                   // [55:32] pixel_color
    output logic [0:0]  m_tuser    // [0] draw_kind
);
    import tcce_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t out_res_reg, out_res_next;
    logic    out_valid_reg, out_valid_next;
    result_t res;
    logic    res_valid;
    logic    advance;
    logic    s_accept;

    tcce_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcce_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item      (in_item_reg),
        .advance   (advance),
        .res       (res),
        .res_valid (res_valid)
    );

    // Advance the held item unless it draws and the result register is stuck.
    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept) begin
            in_valid_next          = 1'b1;
            in_item_next.cmd       = cmd_t'(s_tuser[0]);
            in_item_next.char_code = s_tdata[7:0];
            in_item_next.new_x     = s_tdata[19:8];
            in_item_next.new_y     = s_tdata[31:20];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            // Drop the result once the receiver has taken it.
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.draw_kind;
    assign m_tdata  = {out_res_reg.pixel_color, out_res_reg.glyph_code,
                       out_res_reg.pos_y, out_res_reg.pos_x};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the text console cursor engine: stream and APB stimulus.
module testbench;
    import tcce_pkg::*;

    // Clock, reset and every block input start from a known value.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [7:0] char_code, [19:8] new_x, [31:20] new_y
    logic [0:0]  s_tuser  = '0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [11:0] pos_x, [23:12] pos_y, [31:24] glyph_code,
                                  // [55:32] pixel_color
    logic [0:0]  m_tuser;         // [0] draw_kind

    text_console_cursor_engine_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predicted copy of the engine: register settings and the cursor.
    cfg_t            console_cfg;
    logic [11:0]     pred_x;
    logic [11:0]     pred_y;
    result_t         expected_draws[$];
    int unsigned     draw_mismatches = 0;

    // Idle controls: when off, the matching side never inserts bubbles.
    bit              tx_gaps_on   = 1'b0;
    bit              rx_stalls_on = 1'b0;
    int              rx_hold      = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run (every item waiting out
    // the longest sender gap and the longest receiver stall).
    initial begin
        #(12 * 2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short bubbles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic int unsigned sat_minus(int unsigned a, int unsigned b);
        return (a > b) ? (a - b) : 0;
    endfunction

    // Line advance with wrap back to the top row near the bottom edge.
    function automatic logic [11:0] next_row_wrapped();
        int unsigned ny;
        ny = 32'(pred_y) + 32'(console_cfg.char_height);
        if (ny >= sat_minus(32'(console_cfg.screen_height), 32'(console_cfg.char_height)))
            ny = 32'(HOME_Y);
        return ny[11:0];
    endfunction

    // Update the predicted cursor for one accepted transaction and queue
    // the draw command it causes, if any.
    task automatic advance_cursor(input item_t it);
        int unsigned x_edge;
        int unsigned nx;
        result_t     draw;
        x_edge = sat_minus(32'(console_cfg.screen_width), 32'(CELL_W));
        if (it.cmd == CMD_SET_CURSOR) begin
            pred_x = it.new_x;
            pred_y = it.new_y;
        end else if (it.char_code == CH_BACKSPACE) begin
            // Blocked at the left margin: no move, no erase.
            if (CMP_W'(pred_x) > BS_LIMIT) begin
                pred_x = pred_x - 12'd8;
                draw.draw_kind   = DRAW_ERASE;
                draw.pos_x       = pred_x;
                draw.pos_y       = pred_y;
                draw.glyph_code  = ERASE_GLYPH;
                draw.pixel_color = ERASE_COLOR;
                expected_draws.push_back(draw);
            end
        end else if (it.char_code == CH_NEWLINE) begin
            pred_x = 12'(HOME_X);
            pred_y = next_row_wrapped();
        end else if (it.char_code == CH_TAB) begin
            nx = (32'(pred_x) / 32'(TAB_STEP) + 32'd1) * 32'(TAB_STEP);
            if (nx >= x_edge) begin
                // Tab past the right edge: no bottom wrap, row wraps modulo 4096.
                pred_x = 12'(HOME_X);
                pred_y = pred_y + 12'(console_cfg.char_height);
            end else begin
                pred_x = nx[11:0];
            end
        end else begin
            draw.draw_kind   = DRAW_GLYPH;
            draw.pos_x       = pred_x;
            draw.pos_y       = pred_y;
            draw.glyph_code  = it.char_code;
            draw.pixel_color = console_cfg.fg_color;
            expected_draws.push_back(draw);
            nx = 32'(pred_x) + 32'(CELL_W);
            if (nx >= x_edge) begin
                pred_x = 12'(HOME_X);
                pred_y = next_row_wrapped();
            end else begin
                pred_x = nx[11:0];
            end
        end
    endtask

    function automatic item_t put_char(input logic [7:0] code);
        item_t it;
        it.cmd       = CMD_PUT_CHAR;
        it.char_code = code;
        it.new_x     = 12'($urandom);
        it.new_y     = 12'($urandom);
        return it;
    endfunction

    function automatic item_t set_cursor(input logic [11:0] x, input logic [11:0] y);
        item_t it;
        it.cmd       = CMD_SET_CURSOR;
        it.char_code = 8'($urandom);
        it.new_x     = x;
        it.new_y     = y;
        return it;
    endfunction

    // Offer one transaction on the input stream; tvalid stays high on return
    // so back-to-back transactions need no bubble.
    task automatic send_console_item(input item_t it);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.new_y, it.new_x, it.char_code};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        advance_cursor(it);
    endtask

    // Drop tvalid and hold until every queued draw command is out, then let
    // the pipeline drain items that draw nothing.
    task automatic wait_engine_idle();
        s_tvalid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_console_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  console_cfg.screen_width  = value[11:0];
            REG_SCREEN_HEIGHT: console_cfg.screen_height = value[11:0];
            REG_CHAR_HEIGHT:   console_cfg.char_height   = value[5:0];
            REG_FG_COLOR:      console_cfg.fg_color      = value[23:0];
            default: ;
        endcase
    endtask

    task automatic configure_console(input logic [11:0] w, input logic [11:0] h,
                                     input logic [5:0] ch, input logic [23:0] color);
        wait_engine_idle();
        write_console_reg(REG_SCREEN_WIDTH, 32'(w));
        write_console_reg(REG_SCREEN_HEIGHT, 32'(h));
        write_console_reg(REG_CHAR_HEIGHT, 32'(ch));
        write_console_reg(REG_FG_COLOR, 32'(color));
    endtask

    function automatic void compare_field(input string name, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v) begin
            draw_mismatches++;
            $display("%0t draw command %s mismatch: expected %0h actual %0h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Result side: check every accepted draw command against the oldest
    // prediction, then pick the next tready value.
    always @(posedge aclk) begin
        result_t exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                draw_mismatches++;
                $display("%0t unexpected draw command: tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
            end else begin
                exp_d = expected_draws.pop_front();
                compare_field("draw_kind", exp_d.draw_kind, m_tuser[0]);
                compare_field("pos_x", exp_d.pos_x, m_tdata[11:0]);
                compare_field("pos_y", exp_d.pos_y, m_tdata[23:12]);
                compare_field("glyph_code", exp_d.glyph_code, m_tdata[31:24]);
                compare_field("pixel_color", exp_d.pixel_color, m_tdata[55:32]);
            end
        end
        if (!rx_stalls_on) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                rx_hold = pick_gap();
        end
    end

    // Default geometry: margins, backspace limit, tab stops, both wraps,
    // the overflowing edge compare and the tab row overflow.
    task automatic test_directed_edges();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_console_item(put_char(8'h41));                 // glyph at the reset position
        send_console_item(put_char(8'h00));                 // lowest code
        send_console_item(put_char(CH_BACKSPACE));          // x = 26: blocked
        send_console_item(put_char(8'hFF));                 // highest code
        send_console_item(put_char(CH_BACKSPACE));          // erase one cell back
        send_console_item(put_char(CH_TAB));
        send_console_item(put_char(CH_NEWLINE));
        // Coordinates at their maximum: the advance overflows 12 bits.
        send_console_item(set_cursor(12'hFFF, 12'hFFF));
        send_console_item(put_char(8'h42));
        // Right edge reached on the second glyph, then bottom wrap.
        send_console_item(set_cursor(12'd616, 12'd460));
        send_console_item(put_char(8'h43));
        send_console_item(put_char(8'h44));
        // Tab past the edge with the row wrapping modulo 4096.
        send_console_item(set_cursor(12'd620, 12'd4090));
        send_console_item(put_char(CH_TAB));
        send_console_item(set_cursor(12'd27, 12'd100));
        send_console_item(put_char(CH_BACKSPACE));
        send_console_item(set_cursor(12'd0, 12'd0));
        send_console_item(put_char(CH_TAB));
        send_console_item(put_char(CH_NEWLINE));
    endtask

    // Zero line advance: newline only homes x unless already past the bottom.
    task automatic test_zero_line_advance();
        configure_console(RESET_SCREEN_WIDTH, RESET_SCREEN_HEIGHT, 6'd0, 24'hA55A3C);
        send_console_item(set_cursor(12'd600, 12'd470));
        send_console_item(put_char(CH_NEWLINE));
        send_console_item(put_char(8'h78));
        send_console_item(set_cursor(12'd100, 12'd490));
        send_console_item(put_char(CH_NEWLINE));
    endtask

    // Screen smaller than a cell: both edge limits saturate at zero.
    task automatic test_small_screen();
        configure_console(12'd5, 12'd20, 6'd32, 24'h123456);
        send_console_item(put_char(8'h71));
        send_console_item(put_char(CH_TAB));
        send_console_item(set_cursor(12'd100, 12'd3000));
        send_console_item(put_char(CH_BACKSPACE));
        send_console_item(put_char(8'h72));
    endtask

    // Random text: mostly random character codes with control codes and cursor moves
    // mixed in, across several register settings and idle patterns.
    task automatic test_random_text();
        item_t       it;
        int          r;
        logic [11:0] w;
        logic [11:0] h;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: configure_console(RESET_SCREEN_WIDTH, RESET_SCREEN_HEIGHT,
                                     RESET_CHAR_HEIGHT, RESET_FG_COLOR);
                1: configure_console(12'd4095, 12'd4095, 6'd32, 24'h000000);
                2: configure_console(12'd64, 12'd64, 6'd1, 24'hFFFFFF);
                default: configure_console(12'($urandom_range(64, 4095)),
                                           12'($urandom_range(64, 4095)),
                                           6'($urandom_range(1, 32)),
                                           24'($urandom));
            endcase
            tx_gaps_on   = (phase == 1) || (phase == 2) || (phase == 4);
            rx_stalls_on = (phase == 1) || (phase == 3) || (phase == 4);
            w = console_cfg.screen_width;
            h = console_cfg.screen_height;
            repeat (200) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    // Half the moves land on screen, half anywhere.
                    if ($urandom_range(0, 1))
                        it = set_cursor(12'($urandom_range(0, w - 1)),
                                        12'($urandom_range(0, h - 1)));
                    else
                        it = set_cursor(12'($urandom), 12'($urandom));
                end else if (r < 18) begin
                    it = put_char(CH_BACKSPACE);
                end else if (r < 26) begin
                    it = put_char(CH_NEWLINE);
                end else if (r < 34) begin
                    it = put_char(CH_TAB);
                end else begin
                    it = put_char(8'($urandom));
                end
                send_console_item(it);
            end
        end
    endtask

    initial begin
        console_cfg.screen_width  = RESET_SCREEN_WIDTH;
        console_cfg.screen_height = RESET_SCREEN_HEIGHT;
        console_cfg.char_height   = RESET_CHAR_HEIGHT;
        console_cfg.fg_color      = RESET_FG_COLOR;
        pred_x = RESET_X;
        pred_y = RESET_Y;

        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_zero_line_advance();
        test_small_screen();
        test_random_text();

        // Drain: every prediction must be matched before the verdict.
        wait_engine_idle();
        if (draw_mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
